FILE: rtl/snft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Spectral noise floor tracker package
// Shared widths, reset values, fixed weights, register indexes and the
// structures that travel between the storage and the datapath.
// ----------------------------------------------------------------------------
package snft_pkg;

    localparam int BINS_DEFAULT = 256;
    localparam int POWER_W      = 32;
    localparam int COEF_W       = 16;
    localparam int SPLIT_W      = 9;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 3;

    localparam logic [COEF_W-1:0]  SMOOTHING_RESET  = 16'd45875;
    localparam logic [COEF_W-1:0]  PRESENCE_RESET   = 16'd13107;
    localparam logic [COEF_W-1:0]  NOISE_RESET      = 16'd62259;
    localparam logic [COEF_W-1:0]  RATIO_LOW_RESET  = 16'd4096;
    localparam logic [COEF_W-1:0]  RATIO_HIGH_RESET = 16'd6144;
    localparam logic [SPLIT_W-1:0] SPLIT_RESET      = 9'd39;

    // Minimum tracking weights 0.97, 0.02 and 0.008 in Q0.16.
    localparam logic [COEF_W-1:0] W_MIN_PREV = 16'd63570;
    localparam logic [COEF_W-1:0] W_MIN_CUR  = 16'd1311;
    localparam logic [COEF_W-1:0] W_MIN_OLD  = 16'd524;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SMOOTHING  = 3'd0,
        REG_PRESENCE   = 3'd1,
        REG_NOISE      = 3'd2,
        REG_RATIO_LOW  = 3'd3,
        REG_RATIO_HIGH = 3'd4,
        REG_SPLIT_BIN  = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [COEF_W-1:0] smoothing;
        logic [COEF_W-1:0] presence_decay;
        logic [COEF_W-1:0] noise_decay;
        logic [COEF_W-1:0] ratio_low;
        logic [COEF_W-1:0] ratio_high;
    } coef_t;

    typedef struct packed {
        logic [POWER_W-1:0] s;
        logic [POWER_W-1:0] m;
        logic [POWER_W-1:0] n;
        logic [COEF_W-1:0]  pr;
    } bin_data_t;

    typedef struct packed {
        logic               en;
        logic               first;
        logic [POWER_W-1:0] s;
        logic [POWER_W-1:0] m;
        logic [POWER_W-1:0] n;
        logic [COEF_W-1:0]  pr;
    } wb_t;

endpackage
`default_nettype wire

FILE: rtl/snft_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Spectral noise floor tracker per-bin storage
// Four single-port-write memories holding smoothed power, tracked minimum,
// presence probability and noise estimate, read on request entry with a
// registered output. The presence memory is zeroed by a sweep after reset.
// ----------------------------------------------------------------------------
module snft_store #(
    parameter int BINS = snft_pkg::BINS_DEFAULT,
    localparam int BIN_W = $clog2(BINS)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  rd_en,
    input  wire logic [BIN_W-1:0]      rd_addr,
    output snft_pkg::bin_data_t        rd_data,
    input  wire snft_pkg::wb_t         wb,
    input  wire logic [BIN_W-1:0]      wb_addr,
    output logic                       clear_busy
);
    import snft_pkg::*;

    logic [POWER_W-1:0] s_mem [BINS];
    logic [POWER_W-1:0] m_mem [BINS];
    logic [POWER_W-1:0] n_mem [BINS];
    logic [COEF_W-1:0]  pr_mem [BINS];

    bin_data_t          rd_data_reg;
    logic               clear_busy_reg;
    logic [BIN_W-1:0]   clr_cnt_reg;
    logic               pr_we;
    logic [BIN_W-1:0]   pr_addr;
    logic [COEF_W-1:0]  pr_wdata;

    assign rd_data    = rd_data_reg;
    assign clear_busy = clear_busy_reg;

    assign pr_we    = clear_busy_reg | (wb.en & ~wb.first);
    assign pr_addr  = clear_busy_reg ? clr_cnt_reg : wb_addr;
    assign pr_wdata = clear_busy_reg ? '0 : wb.pr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else if (clear_busy_reg)
        begin
            if (clr_cnt_reg == BIN_W'(BINS - 1))
            begin
                clear_busy_reg <= 1'b0;
            end
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wb.en)
        begin
            s_mem[wb_addr] <= wb.s;
            m_mem[wb_addr] <= wb.m;
            n_mem[wb_addr] <= wb.n;
        end
        if (pr_we)
        begin
            pr_mem[pr_addr] <= pr_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg.s  <= s_mem[rd_addr];
            rd_data_reg.m  <= m_mem[rd_addr];
            rd_data_reg.n  <= n_mem[rd_addr];
            rd_data_reg.pr <= pr_mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/snft_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Spectral noise floor tracker update pipeline
// Nine stages from the registered store read to the write-back: power
// smoothing, minimum tracking, presence update and noise blending, followed
// by the output register. Each stage stalls only when the one after it is full and cannot move on.
// ----------------------------------------------------------------------------
module snft_pipe #(
    parameter int BINS = snft_pkg::BINS_DEFAULT,
    localparam int BIN_W = $clog2(BINS)
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_fire,
    input  wire logic [BIN_W-1:0]                in_bin,
    input  wire logic                            in_last,
    input  wire logic                            in_first,
    input  wire logic                            in_high,
    input  wire logic [snft_pkg::POWER_W-1:0]    in_power,
    input  wire snft_pkg::bin_data_t             rd_data,
    input  wire snft_pkg::coef_t                 coef,
    output logic                                 take,
    output logic                                 bin_hit,
    output snft_pkg::wb_t                        wb,
    output logic [BIN_W-1:0]                     wb_addr,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [snft_pkg::POWER_W-1:0]         noise_power,
    output logic                                 frame_end
);
    import snft_pkg::*;

    localparam int NS   = 9;
    localparam int LAST = NS - 1;

    logic [NS-1:0]      valid_reg;
    logic [NS-1:0]      valid_next;
    logic [NS-1:0]      adv;
    logic [BIN_W-1:0]   bin_reg [NS];
    logic [NS-1:0]      last_reg;
    logic [NS-1:0]      first_reg;
    logic [NS-1:0]      high_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [POWER_W-1:0] out_noise_reg;
    logic               out_end_reg;

    // Stage 0
    logic [POWER_W-1:0] p0_reg;
    // Stage 1
    logic [16:0]        inv_a;
    logic [16:0]        inv_d;
    logic [47:0]        as1_next, as1_reg;
    logic [48:0]        ap1_next, ap1_reg;
    logic [47:0]        mm1_next, mm1_reg;
    logic [41:0]        ms1_next, ms1_reg;
    logic [32:0]        acc0_1_next, acc0_1_reg;
    logic [32:0]        acc1_1_next, acc1_1_reg;
    logic [POWER_W-1:0] m1_reg, n1_reg, p1_reg;
    // Stage 2
    logic [48:0]        s_sum;
    logic [POWER_W-1:0] s2_next, s2_reg;
    logic [47:0]        mm2_reg;
    logic [41:0]        ms2_reg;
    logic [32:0]        acc0_2_reg, acc1_2_reg;
    logic [POWER_W-1:0] m2_reg, n2_reg;
    // Stage 3
    logic [42:0]        mc3_next, mc3_reg;
    logic               less3_reg;
    logic [POWER_W-1:0] s3_reg, n3_reg;
    logic [47:0]        mm3_reg;
    logic [41:0]        ms3_reg;
    logic [32:0]        acc0_3_reg, acc1_3_reg;
    // Stage 4
    logic [49:0]        t_sum;
    logic [POWER_W-1:0] m4_next, m4_reg;
    logic [POWER_W-1:0] s4_reg, n4_reg;
    logic [32:0]        acc0_4_reg, acc1_4_reg;
    // Stage 5
    logic [47:0]        rm5_next, rm5_reg;
    logic [POWER_W-1:0] s5_reg, m5_reg, n5_reg;
    logic [32:0]        acc0_5_reg, acc1_5_reg;
    // Stage 6
    logic [32:0]        pr_acc;
    logic [COEF_W-1:0]  pk6_next, pk6_reg;
    logic [POWER_W-1:0] s6_reg, m6_reg, n6_reg;
    // Stage 7
    logic [16:0]        inv_n;
    logic [33:0]        w_sum;
    logic [POWER_W-1:0] w7_next, w7_reg;
    logic [POWER_W-1:0] s7_reg, m7_reg, n7_reg;
    logic [COEF_W-1:0]  pk7_reg;
    // Stage 8
    logic [32:0]        inv_w;
    logic [63:0]        wn8_next, wn8_reg;
    logic [64:0]        ws8_next, ws8_reg;
    logic [POWER_W-1:0] s8_reg, m8_reg;
    logic [COEF_W-1:0]  pk8_reg;
    // Retire
    logic [65:0]        n_sum;
    logic [POWER_W-1:0] result;

    always_comb
    begin
        adv[LAST] = valid_reg[LAST] & (~out_valid_reg | out_ready);
        for (int i = LAST - 1; i >= 0; i--)
        begin
            adv[i] = valid_reg[i] & (~valid_reg[i+1] | adv[i+1]);
        end
    end

    always_comb
    begin
        valid_next[0] = in_fire | (valid_reg[0] & ~adv[0]);
        for (int i = 1; i < NS; i++)
        begin
            valid_next[i] = adv[i-1] | (valid_reg[i] & ~adv[i]);
        end
        out_valid_next = adv[LAST] | (out_valid_reg & ~out_ready);
    end

    always_comb
    begin
        bin_hit = 1'b0;
        for (int i = 0; i < NS; i++)
        begin
            if (valid_reg[i] && (bin_reg[i] == in_bin))
            begin
                bin_hit = 1'b1;
            end
        end
    end

    assign take = ~valid_reg[0] | adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            bin_reg[0]   <= in_bin;
            last_reg[0]  <= in_last;
            first_reg[0] <= in_first;
            high_reg[0]  <= in_high;
            p0_reg       <= in_power;
        end
        for (int i = 1; i < NS; i++)
        begin
            if (adv[i-1])
            begin
                bin_reg[i]   <= bin_reg[i-1];
                last_reg[i]  <= last_reg[i-1];
                first_reg[i] <= first_reg[i-1];
                high_reg[i]  <= high_reg[i-1];
            end
        end
    end

    // Smoothing and minimum products, presence candidates.
    always_comb
    begin
        inv_a       = 17'd65536 - {1'b0, coef.smoothing};
        inv_d       = 17'd65536 - {1'b0, coef.presence_decay};
        as1_next    = coef.smoothing * rd_data.s;
        ap1_next    = inv_a * p0_reg;
        mm1_next    = W_MIN_PREV * rd_data.m;
        ms1_next    = W_MIN_OLD * rd_data.s;
        acc0_1_next = coef.presence_decay * rd_data.pr + 33'd32768;
        acc1_1_next = acc0_1_next + {inv_d, 16'b0};
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            as1_reg    <= as1_next;
            ap1_reg    <= ap1_next;
            mm1_reg    <= mm1_next;
            ms1_reg    <= ms1_next;
            acc0_1_reg <= acc0_1_next;
            acc1_1_reg <= acc1_1_next;
            m1_reg     <= rd_data.m;
            n1_reg     <= rd_data.n;
            p1_reg     <= p0_reg;
        end
    end

    // New smoothed power; a first-frame request loads the input power.
    always_comb
    begin
        s_sum   = {1'b0, as1_reg} + ap1_reg + 49'd32768;
        s2_next = first_reg[1] ? p1_reg : s_sum[47:16];
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s2_reg     <= s2_next;
            mm2_reg    <= mm1_reg;
            ms2_reg    <= ms1_reg;
            acc0_2_reg <= acc0_1_reg;
            acc1_2_reg <= acc1_1_reg;
            m2_reg     <= m1_reg;
            n2_reg     <= n1_reg;
        end
    end

    assign mc3_next = W_MIN_CUR * s2_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            mc3_reg    <= mc3_next;
            less3_reg  <= m2_reg < s2_reg;
            s3_reg     <= s2_reg;
            n3_reg     <= n2_reg;
            mm3_reg    <= mm2_reg;
            ms3_reg    <= ms2_reg;
            acc0_3_reg <= acc0_2_reg;
            acc1_3_reg <= acc1_2_reg;
        end
    end

    // Minimum follows the smoothed power upward slowly, clamped at zero.
    always_comb
    begin
        t_sum = {2'b0, mm3_reg} + {7'b0, mc3_reg} + 50'd32768 - {8'b0, ms3_reg};
        if (first_reg[3] || !less3_reg)
        begin
            m4_next = s3_reg;
        end
        else if (t_sum[49])
        begin
            m4_next = '0;
        end
        else
        begin
            m4_next = t_sum[47:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            m4_reg     <= m4_next;
            s4_reg     <= s3_reg;
            n4_reg     <= n3_reg;
            acc0_4_reg <= acc0_3_reg;
            acc1_4_reg <= acc1_3_reg;
        end
    end

    assign rm5_next = (high_reg[4] ? coef.ratio_high : coef.ratio_low) * m4_reg;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            rm5_reg    <= rm5_next;
            s5_reg     <= s4_reg;
            m5_reg     <= m4_reg;
            n5_reg     <= n4_reg;
            acc0_5_reg <= acc0_4_reg;
            acc1_5_reg <= acc1_4_reg;
        end
    end

    // Presence rises when the smoothed power clears ratio times minimum.
    always_comb
    begin
        pr_acc   = ({4'b0, s5_reg, 12'b0} > rm5_reg) ? acc1_5_reg : acc0_5_reg;
        pk6_next = pr_acc[32] ? {COEF_W{1'b1}} : pr_acc[31:16];
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            pk6_reg <= pk6_next;
            s6_reg  <= s5_reg;
            m6_reg  <= m5_reg;
            n6_reg  <= n5_reg;
        end
    end

    always_comb
    begin
        inv_n   = 17'd65536 - {1'b0, coef.noise_decay};
        w_sum   = inv_n * pk6_reg + {2'b0, coef.noise_decay, 16'b0};
        w7_next = w_sum[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            w7_reg  <= w7_next;
            s7_reg  <= s6_reg;
            m7_reg  <= m6_reg;
            n7_reg  <= n6_reg;
            pk7_reg <= pk6_reg;
        end
    end

    always_comb
    begin
        inv_w    = {1'b1, 32'b0} - {1'b0, w7_reg};
        wn8_next = w7_reg * n7_reg;
        ws8_next = inv_w * s7_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            wn8_reg <= wn8_next;
            ws8_reg <= ws8_next;
            s8_reg  <= s7_reg;
            m8_reg  <= m7_reg;
            pk8_reg <= pk7_reg;
        end
    end

    always_comb
    begin
        n_sum  = {2'b0, wn8_reg} + {1'b0, ws8_reg} + 66'h8000_0000;
        result = first_reg[LAST] ? s8_reg : n_sum[63:32];
    end

    always_comb
    begin
        wb.en    = adv[LAST];
        wb.first = first_reg[LAST];
        wb.s     = s8_reg;
        wb.m     = m8_reg;
        wb.n     = result;
        wb.pr    = pk8_reg;
        wb_addr  = bin_reg[LAST];
    end

    always_ff @(posedge clk)
    begin
        if (adv[LAST])
        begin
            out_noise_reg <= result;
            out_end_reg   <= last_reg[LAST];
        end
    end

    assign out_valid   = out_valid_reg;
    assign noise_power = out_noise_reg;
    assign frame_end   = out_end_reg;

endmodule
`default_nettype wire

FILE: rtl/spectral_noise_floor_tracker_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Spectral noise floor tracker
// Per-bin noise floor estimate with minimum tracking and speech presence.
// ----------------------------------------------------------------------------
// Takes one power bin per cycle when neither out_ready back-pressure nor the
// same-bin check below holds it off, and returns its noise estimate; the
// accepting edge loads the store read, then eight arithmetic stages follow
// and the last of them feeds the output register. Each bin's stores are read
// when its request enters and written when it leaves the last stage, so a
// request is held off while an earlier request for the same bin is still in
// the nine stages: frames of at least ten bins stream at one bin per cycle,
// shorter frames wait for the earlier request. After reset the presence store
// is cleared one entry per cycle, and in_ready stays low until the sweep ends.
// ----------------------------------------------------------------------------
module spectral_noise_floor_tracker_top #(
    parameter int BINS = snft_pkg::BINS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [snft_pkg::POWER_W-1:0]        power,
    input  wire logic                                last_bin,
    input  wire logic                                first_frame,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [snft_pkg::POWER_W-1:0]             noise_power,
    output logic                                     frame_end,
    input  wire logic                                cfg_wr_en,
    input  wire logic [snft_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [snft_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import snft_pkg::*;

    localparam int BIN_W = $clog2(BINS);
    localparam int CMP_W = (BIN_W > SPLIT_W) ? BIN_W : SPLIT_W;

    coef_t              coef_reg;
    logic [SPLIT_W-1:0] split_reg;
    logic [BIN_W-1:0]   bin_reg;
    logic [BIN_W-1:0]   bin_next;
    logic               in_fire;
    logic               use_high;
    logic               take;
    logic               bin_hit;
    logic               clear_busy;
    bin_data_t          rd_data;
    wb_t                wb;
    logic [BIN_W-1:0]   wb_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.smoothing      <= SMOOTHING_RESET;
            coef_reg.presence_decay <= PRESENCE_RESET;
            coef_reg.noise_decay    <= NOISE_RESET;
            coef_reg.ratio_low      <= RATIO_LOW_RESET;
            coef_reg.ratio_high     <= RATIO_HIGH_RESET;
            split_reg               <= SPLIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SMOOTHING:  coef_reg.smoothing      <= cfg_data;
                REG_PRESENCE:   coef_reg.presence_decay <= cfg_data;
                REG_NOISE:      coef_reg.noise_decay    <= cfg_data;
                REG_RATIO_LOW:  coef_reg.ratio_low      <= cfg_data;
                REG_RATIO_HIGH: coef_reg.ratio_high     <= cfg_data;
                REG_SPLIT_BIN:  split_reg               <= cfg_data[SPLIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign in_ready = ~clear_busy & take & ~bin_hit;
    assign in_fire  = in_valid & in_ready;
    assign use_high = CMP_W'(bin_reg) >= CMP_W'(split_reg);

    always_comb
    begin
        if (last_bin || (bin_reg == BIN_W'(BINS - 1)))
        begin
            bin_next = '0;
        end
        else
        begin
            bin_next = bin_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_reg <= '0;
        end
        else if (in_fire)
        begin
            bin_reg <= bin_next;
        end
    end

    snft_store #(
        .BINS (BINS)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (in_fire),
        .rd_addr    (bin_reg),
        .rd_data    (rd_data),
        .wb         (wb),
        .wb_addr    (wb_addr),
        .clear_busy (clear_busy)
    );

    snft_pipe #(
        .BINS (BINS)
    ) u_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .in_bin      (bin_reg),
        .in_last     (last_bin),
        .in_first    (first_frame),
        .in_high     (use_high),
        .in_power    (power),
        .rd_data     (rd_data),
        .coef        (coef_reg),
        .take        (take),
        .bin_hit     (bin_hit),
        .wb          (wb),
        .wb_addr     (wb_addr),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .noise_power (noise_power),
        .frame_end   (frame_end)
    );

endmodule
`default_nettype wire
